[design/arrt_pkg.sv]
package arrt_pkg;

    localparam int PORT_AW = 48;
    localparam int LEN_W   = 49;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_APPEND    = 3'd1;
    localparam logic [2:0] OP_LOCATE    = 3'd2;
    localparam logic [2:0] OP_INTERSECT = 3'd3;
    localparam logic [2:0] OP_GAP       = 3'd4;
    localparam logic [2:0] OP_PROTECT   = 3'd5;
    localparam logic [2:0] OP_UNMAP     = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NONE    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ORDER   = 3'd4;

endpackage

[design/arrt_ram.sv]
module arrt_ram #(
    parameter int DEPTH = 16,
    parameter int IW    = 4,
    parameter int DW    = 108
) (
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/address_range_region_table_top.sv]
// Clear and items rejected on their fields go straight to the result; an append to an
// empty table writes at once, other appends first read the last entry; scans read entries
// in order; unmap rebuilds every entry, protect scans its cover and then rebuilds too.
// Throughput: one item at a time; in_ready is high only while the sequencer is idle.
// Rebuilds write the idle one of two ping-pong banks and flip only when they fit.
// Reset (rst_n low, asynchronous) empties the table and drops any pending result.
module address_range_region_table_top #(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     operation,
    input  logic [arrt_pkg::PORT_AW-1:0]   addr_start,
    input  logic [arrt_pkg::PORT_AW-1:0]   addr_end,
    input  logic [arrt_pkg::LEN_W-1:0]     gap_length,
    input  logic [3:0]                     new_permissions,
    input  logic [7:0]                     owner_tag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     status,
    output logic                           contains,
    output logic                           found,
    output logic [arrt_pkg::PORT_AW-1:0]   hit_start,
    output logic [arrt_pkg::PORT_AW-1:0]   hit_end,
    output logic [3:0]                     hit_permissions,
    output logic [7:0]                     hit_owner,
    output logic [arrt_pkg::PORT_AW-1:0]   gap_address,
    output logic [$clog2(MAX_REGIONS+1)-1:0] region_count
);
    import arrt_pkg::*;

    localparam int AW = (ADDR_BITS < PORT_AW) ? ADDR_BITS : PORT_AW;
    localparam int DW = 2 * AW + 12;
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int NW = $clog2(3 * MAX_REGIONS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_APP   = 4'd3;
    localparam logic [3:0] S_SEND  = 4'd4;
    localparam logic [3:0] S_P0    = 4'd5;
    localparam logic [3:0] S_P1    = 4'd6;
    localparam logic [3:0] S_P2    = 4'd7;
    localparam logic [3:0] S_RBEND = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    logic [AW-1:0]    s_reg, s_next, e_reg, e_next, cur_reg, cur_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       perm_reg, perm_next;
    logic [7:0]       owner_reg, owner_next;
    logic [CW-1:0]    idx_reg, idx_next, count_reg, count_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             rb_reg, rb_next, bank_reg, bank_next;
    logic [DW-1:0]    ent_reg, ent_next;

    logic [2:0]       st_reg, st_next;
    logic             cont_reg, cont_next, fnd_reg, fnd_next;
    logic [AW-1:0]    hs_reg, hs_next, he_reg, he_next, gap_reg, gap_next;
    logic [3:0]       hp_reg, hp_next;
    logic [7:0]       ho_reg, ho_next;

    logic             ov_reg, ov_next;
    logic [2:0]       o_st_reg;
    logic             o_cont_reg, o_fnd_reg;
    logic [AW-1:0]    o_hs_reg, o_he_reg, o_gap_reg;
    logic [3:0]       o_hp_reg;
    logic [7:0]       o_ho_reg;
    logic [CW-1:0]    o_cnt_reg;

    logic             wr_en, wr_bank;
    logic [IW-1:0]    wr_addr;
    logic [DW-1:0]    wr_data;
    logic [DW-1:0]    rd0, rd1, rdata;

    logic [AW-1:0]    in_s, in_e, ra, rbd, ea, eb;
    logic [3:0]       rp, ep;
    logic [7:0]       ro, eo;
    logic [CW-1:0]    idx_inc;
    logic             pc_v;
    logic [AW-1:0]    pc_a, pc_b;
    logic [3:0]       pc_p;

    assign in_s = addr_start[AW-1:0];
    assign in_e = addr_end[AW-1:0];
    assign rdata = bank_reg ? rd1 : rd0;
    assign ra  = rdata[DW-1 -: AW];
    assign rbd = rdata[DW-1-AW -: AW];
    assign rp  = rdata[11:8];
    assign ro  = rdata[7:0];
    assign ea  = ent_reg[DW-1 -: AW];
    assign eb  = ent_reg[DW-1-AW -: AW];
    assign ep  = ent_reg[11:8];
    assign eo  = ent_reg[7:0];
    assign idx_inc = idx_reg + CW'(1);
    assign in_ready = (state_reg == S_IDLE);

    arrt_ram #(.DEPTH(MAX_REGIONS), .IW(IW), .DW(DW)) u_bank0 (
        .clk(clk), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_data),
        .raddr(idx_reg[IW-1:0]), .rdata(rd0)
    );

    arrt_ram #(.DEPTH(MAX_REGIONS), .IW(IW), .DW(DW)) u_bank1 (
        .clk(clk), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_data),
        .raddr(idx_reg[IW-1:0]), .rdata(rd1)
    );

    // rebuild pieces of the latched entry
    always_comb
    begin
        pc_v = 1'b0;
        pc_a = ea;
        pc_b = eb;
        pc_p = ep;
        case (state_reg)
            S_P0:
            begin
                if (!ov_reg)
                begin
                    pc_v = 1'b1;
                end
                else if (ea < s_reg)
                begin
                    pc_v = 1'b1;
                    pc_b = s_reg;
                end
            end
            S_P1:
            begin
                pc_v = ov_reg && (op_reg == OP_PROTECT);
                pc_a = (s_reg > ea) ? s_reg : ea;
                pc_b = (e_reg < eb) ? e_reg : eb;
                pc_p = perm_reg;
            end
            S_P2:
            begin
                pc_v = ov_reg && (e_reg < eb);
                pc_a = e_reg;
            end
            default:
            begin
                pc_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        cur_next   = cur_reg;
        len_next   = len_reg;
        perm_next  = perm_reg;
        owner_next = owner_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        n_next     = n_reg;
        rb_next    = rb_reg;
        bank_next  = bank_reg;
        ent_next   = ent_reg;
        ov_next    = ov_reg;
        st_next    = st_reg;
        cont_next  = cont_reg;
        fnd_next   = fnd_reg;
        hs_next    = hs_reg;
        he_next    = he_reg;
        hp_next    = hp_reg;
        ho_next    = ho_reg;
        gap_next   = gap_reg;
        wr_en      = 1'b0;
        wr_bank    = ~bank_reg;
        wr_addr    = n_reg[IW-1:0];
        wr_data    = {pc_a, pc_b, pc_p, eo};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    s_next     = in_s;
                    e_next     = in_e;
                    cur_next   = in_s;
                    len_next   = gap_length;
                    perm_next  = new_permissions;
                    owner_next = owner_tag;
                    idx_next   = '0;
                    n_next     = '0;
                    rb_next    = 1'b0;
                    st_next    = ST_OK;
                    cont_next  = 1'b0;
                    fnd_next   = 1'b0;
                    hs_next    = '0;
                    he_next    = '0;
                    hp_next    = '0;
                    ho_next    = '0;
                    gap_next   = '0;
                    state_next = (count_reg == '0) ? S_SEND : S_RD;
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_FIN;
                        end
                        OP_APPEND:
                        begin
                            if (in_s >= in_e)
                            begin
                                st_next    = ST_INVALID;
                                state_next = S_FIN;
                            end
                            else if (count_reg != '0)
                            begin
                                idx_next   = count_reg - CW'(1);
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_APP;
                            end
                        end
                        OP_LOCATE:
                        begin
                            st_next = ST_OK;
                        end
                        OP_INTERSECT, OP_PROTECT:
                        begin
                            if (in_s >= in_e)
                            begin
                                st_next    = ST_INVALID;
                                state_next = S_FIN;
                            end
                        end
                        OP_GAP:
                        begin
                            if (in_s >= in_e || gap_length == '0)
                            begin
                                st_next    = ST_INVALID;
                                state_next = S_FIN;
                            end
                            else if (gap_length > (LEN_W'(in_e) - LEN_W'(in_s)))
                            begin
                                st_next    = ST_NONE;
                                state_next = S_FIN;
                            end
                        end
                        OP_UNMAP:
                        begin
                            if (in_s >= in_e)
                            begin
                                st_next    = ST_INVALID;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                rb_next    = 1'b1;
                                state_next = (count_reg == '0) ? S_RBEND : S_RD;
                            end
                        end
                        default:
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                ent_next = rdata;
                if (rb_reg)
                begin
                    ov_next    = !(e_reg <= ra || rbd <= s_reg);
                    state_next = S_P0;
                end
                else
                begin
                    state_next = (idx_inc >= count_reg) ? S_SEND : S_RD;
                    idx_next   = idx_inc;
                    case (op_reg)
                        OP_APPEND:
                        begin
                            state_next = S_APP;
                            idx_next   = idx_reg;
                        end
                        OP_LOCATE, OP_INTERSECT:
                        begin
                            if (s_reg < rbd)
                            begin
                                state_next = S_FIN;
                                if (op_reg == OP_LOCATE || ra < e_reg)
                                begin
                                    fnd_next  = 1'b1;
                                    cont_next = (op_reg == OP_LOCATE) && (ra <= s_reg);
                                    hs_next   = ra;
                                    he_next   = rbd;
                                    hp_next   = rp;
                                    ho_next   = ro;
                                end
                                else
                                begin
                                    st_next = ST_NONE;
                                end
                            end
                        end
                        OP_GAP:
                        begin
                            if (rbd > cur_reg)
                            begin
                                if (ra >= e_reg)
                                begin
                                    state_next = S_SEND;
                                end
                                else if (ra > cur_reg &&
                                         len_reg <= (LEN_W'(ra) - LEN_W'(cur_reg)))
                                begin
                                    gap_next   = cur_reg;
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    cur_next = rbd;
                                    if (rbd >= e_reg)
                                    begin
                                        st_next    = ST_NONE;
                                        state_next = S_FIN;
                                    end
                                end
                            end
                        end
                        OP_PROTECT:
                        begin
                            if (rbd > cur_reg)
                            begin
                                if (ra > cur_reg)
                                begin
                                    st_next    = ST_NONE;
                                    state_next = S_FIN;
                                end
                                else
                                begin
                                    cur_next = (e_reg < rbd) ? e_reg : rbd;
                                    if (e_reg <= rbd)
                                    begin
                                        rb_next    = 1'b1;
                                        idx_next   = '0;
                                        n_next     = '0;
                                        state_next = S_RD;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_APP:
            begin
                state_next = S_FIN;
                if (count_reg != '0 && eb > s_reg)
                begin
                    st_next = ST_ORDER;
                end
                else if (count_reg >= CW'(MAX_REGIONS))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_bank    = bank_reg;
                    wr_addr    = count_reg[IW-1:0];
                    wr_data    = {s_reg, e_reg, perm_reg, owner_reg};
                    count_next = count_reg + CW'(1);
                end
            end
            S_SEND:
            begin
                state_next = S_FIN;
                case (op_reg)
                    OP_GAP:
                    begin
                        if (len_reg <= (LEN_W'(e_reg) - LEN_W'(cur_reg)))
                        begin
                            gap_next = cur_reg;
                        end
                        else
                        begin
                            st_next = ST_NONE;
                        end
                    end
                    OP_PROTECT:
                    begin
                        if (cur_reg == e_reg && count_reg != '0)
                        begin
                            rb_next    = 1'b1;
                            idx_next   = '0;
                            n_next     = '0;
                            state_next = S_RD;
                        end
                        else
                        begin
                            st_next = ST_NONE;
                        end
                    end
                    default:
                    begin
                        st_next = ST_NONE;
                    end
                endcase
            end
            S_P0, S_P1, S_P2:
            begin
                if (pc_v)
                begin
                    wr_en  = (n_reg < NW'(MAX_REGIONS));
                    n_next = n_reg + NW'(1);
                end
                if (state_reg == S_P0)
                begin
                    state_next = S_P1;
                end
                else if (state_reg == S_P1)
                begin
                    state_next = S_P2;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc >= count_reg) ? S_RBEND : S_RD;
                end
            end
            S_RBEND:
            begin
                state_next = S_FIN;
                if (n_reg > NW'(MAX_REGIONS))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    bank_next  = ~bank_reg;
                    count_next = n_reg[CW-1:0];
                end
            end
            S_FIN:
            begin
                if (!out_valid || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bank_reg  <= 1'b0;
            rb_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bank_reg  <= bank_next;
            rb_reg    <= rb_next;
            if (state_reg == S_FIN && (!out_valid || out_ready))
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        cur_reg   <= cur_next;
        len_reg   <= len_next;
        perm_reg  <= perm_next;
        owner_reg <= owner_next;
        idx_reg   <= idx_next;
        n_reg     <= n_next;
        ent_reg   <= ent_next;
        ov_reg    <= ov_next;
        st_reg    <= st_next;
        cont_reg  <= cont_next;
        fnd_reg   <= fnd_next;
        hs_reg    <= hs_next;
        he_reg    <= he_next;
        hp_reg    <= hp_next;
        ho_reg    <= ho_next;
        gap_reg   <= gap_next;
        if (state_reg == S_FIN && (!out_valid || out_ready))
        begin
            o_st_reg   <= st_reg;
            o_cont_reg <= cont_reg;
            o_fnd_reg  <= fnd_reg;
            o_hs_reg   <= hs_reg;
            o_he_reg   <= he_reg;
            o_hp_reg   <= hp_reg;
            o_ho_reg   <= ho_reg;
            o_gap_reg  <= (st_reg == ST_OK) ? gap_reg : '0;
            o_cnt_reg  <= count_reg;
        end
    end

    assign status          = o_st_reg;
    assign contains        = o_cont_reg;
    assign found           = o_fnd_reg;
    assign hit_start       = PORT_AW'(o_hs_reg);
    assign hit_end         = PORT_AW'(o_he_reg);
    assign hit_permissions = o_hp_reg;
    assign hit_owner       = o_ho_reg;
    assign gap_address     = PORT_AW'(o_gap_reg);
    assign region_count    = o_cnt_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REGIONS))
        else $error("region count above capacity");

    a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_APP || n_reg < NW'(MAX_REGIONS)))
        else $error("rebuild write beyond capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != S_IDLE)
        else $error("item accepted but sequencer idle");

    a_full_keeps_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RBEND && n_reg > NW'(MAX_REGIONS)) |=>
        (bank_reg == $past(bank_reg) && count_reg == $past(count_reg)))
        else $error("refused rebuild changed the table");
`endif

endmodule

[verif/tb_address_range_region_table_top.sv]
module tb_address_range_region_table_top;
    import arrt_pkg::*;

    localparam int NREG = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] s;
        logic [47:0] e;
        logic [48:0] len;
        logic [3:0]  perm;
        logic [7:0]  owner;
    } req_t;

    typedef struct packed {
        logic [2:0]  st;
        logic        cont;
        logic        fnd;
        logic [47:0] hs;
        logic [47:0] he;
        logic [3:0]  hp;
        logic [7:0]  ho;
        logic [47:0] ga;
        logic [4:0]  cnt;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] operation = '0;
    logic [47:0] addr_start = '0;
    logic [47:0] addr_end = '0;
    logic [48:0] gap_length = '0;
    logic [3:0] new_permissions = '0;
    logic [7:0] owner_tag = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic contains;
    logic found;
    logic [47:0] hit_start;
    logic [47:0] hit_end;
    logic [3:0] hit_permissions;
    logic [7:0] hit_owner;
    logic [47:0] gap_address;
    logic [4:0] region_count;

    address_range_region_table_top i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor's copy of the table
    logic [47:0] tbl_s [NREG];
    logic [47:0] tbl_e [NREG];
    logic [3:0]  tbl_p [NREG];
    logic [7:0]  tbl_o [NREG];
    int tbl_n = 0;

    rsp_t pending_rsp[$];
    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_rx = 0;
    int op_hits [8];
    int st_hits [8];

    function automatic int first_above(logic [47:0] x);
        for (int i = 0; i < tbl_n; i++)
            if (x < tbl_e[i])
                return i;
        return tbl_n;
    endfunction

    function automatic bit is_covered(logic [47:0] s, logic [47:0] e);
        logic [47:0] cur;
        cur = s;
        for (int i = 0; i < tbl_n; i++)
        begin
            if (tbl_e[i] <= cur)
                continue;
            if (tbl_s[i] > cur)
                return 0;
            cur = (e < tbl_e[i]) ? e : tbl_e[i];
            if (cur == e)
                break;
        end
        return cur == e;
    endfunction

    function automatic bit gap_search(logic [47:0] lo, logic [47:0] hi, logic [48:0] len,
                                      output logic [47:0] at);
        logic [47:0] cur;
        cur = lo;
        at = '0;
        for (int i = 0; i < tbl_n; i++)
        begin
            if (tbl_e[i] <= cur)
                continue;
            if (tbl_s[i] >= hi)
                break;
            if (tbl_s[i] > cur && len <= {1'b0, tbl_s[i] - cur})
            begin
                at = cur;
                return 1;
            end
            if (tbl_e[i] > cur)
                cur = tbl_e[i];
            if (cur >= hi)
                return 0;
        end
        if (len <= {1'b0, hi - cur})
        begin
            at = cur;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit split_table(logic [47:0] s, logic [47:0] e, logic [3:0] perm,
                                       bit erase);
        logic [47:0] ns [NREG+3];
        logic [47:0] ne [NREG+3];
        logic [3:0]  np [NREG+3];
        logic [7:0]  no [NREG+3];
        logic [47:0] ps [3];
        logic [47:0] pe [3];
        logic [3:0]  pp [3];
        bit          pv [3];
        logic [47:0] a;
        logic [47:0] b;
        int n;
        n = 0;
        for (int i = 0; i < tbl_n; i++)
        begin
            a = tbl_s[i];
            b = tbl_e[i];
            pv[0] = 0; pv[1] = 0; pv[2] = 0;
            ps[0] = a; pe[0] = b; pp[0] = tbl_p[i];
            if (e <= a || b <= s)
                pv[0] = 1;
            else
            begin
                pv[0] = a < s; pe[0] = s;
                pv[1] = !erase; ps[1] = s > a ? s : a; pe[1] = e < b ? e : b; pp[1] = perm;
                pv[2] = e < b; ps[2] = e; pe[2] = b; pp[2] = tbl_p[i];
            end
            for (int j = 0; j < 3; j++)
            begin
                if (pv[j])
                begin
                    if (n < NREG + 3)
                    begin
                        ns[n] = ps[j]; ne[n] = pe[j]; np[n] = pp[j]; no[n] = tbl_o[i];
                    end
                    n++;
                end
            end
        end
        if (n > NREG)
            return 0;
        for (int i = 0; i < n; i++)
        begin
            tbl_s[i] = ns[i]; tbl_e[i] = ne[i]; tbl_p[i] = np[i]; tbl_o[i] = no[i];
        end
        tbl_n = n;
        return 1;
    endfunction

    function automatic rsp_t table_step(req_t r);
        rsp_t o;
        int k;
        int hit;
        logic [47:0] at;
        o = '0;
        hit = -1;
        case (r.op)
            OP_CLEAR: tbl_n = 0;
            OP_APPEND:
                if (r.s >= r.e)
                    o.st = ST_INVALID;
                else if (tbl_n > 0 && tbl_e[tbl_n-1] > r.s)
                    o.st = ST_ORDER;
                else if (tbl_n >= NREG)
                    o.st = ST_FULL;
                else
                begin
                    tbl_s[tbl_n] = r.s; tbl_e[tbl_n] = r.e;
                    tbl_p[tbl_n] = r.perm; tbl_o[tbl_n] = r.owner;
                    tbl_n++;
                end
            OP_LOCATE:
            begin
                k = first_above(r.s);
                if (k < tbl_n)
                begin
                    hit = k;
                    o.cont = tbl_s[k] <= r.s;
                end
                else
                    o.st = ST_NONE;
            end
            OP_INTERSECT:
                if (r.s >= r.e)
                    o.st = ST_INVALID;
                else
                begin
                    k = first_above(r.s);
                    if (k < tbl_n && tbl_s[k] < r.e)
                        hit = k;
                    else
                        o.st = ST_NONE;
                end
            OP_GAP:
                if (r.s >= r.e || r.len == 0)
                    o.st = ST_INVALID;
                else if (r.len > {1'b0, r.e - r.s} || !gap_search(r.s, r.e, r.len, at))
                    o.st = ST_NONE;
                else
                    o.ga = at;
            OP_PROTECT:
                if (r.s >= r.e)
                    o.st = ST_INVALID;
                else if (!is_covered(r.s, r.e))
                    o.st = ST_NONE;
                else if (!split_table(r.s, r.e, r.perm, 0))
                    o.st = ST_FULL;
            OP_UNMAP:
                if (r.s >= r.e)
                    o.st = ST_INVALID;
                else if (!split_table(r.s, r.e, 4'd0, 1))
                    o.st = ST_FULL;
            default: o.st = ST_INVALID;
        endcase
        if (hit >= 0)
        begin
            o.fnd = 1'b1;
            o.hs = tbl_s[hit]; o.he = tbl_e[hit]; o.hp = tbl_p[hit]; o.ho = tbl_o[hit];
        end
        o.cnt = tbl_n[4:0];
        return o;
    endfunction

    // directed rows; chk marks rows whose expectation is typed in
    typedef struct packed {
        req_t r;
        bit   chk;
        rsp_t x;
    } row_t;

    localparam logic [47:0] AMAX = 48'hFFFF_FFFF_FFFF;

    function automatic row_t mk(logic [2:0] op, logic [47:0] s, logic [47:0] e,
                                logic [48:0] len, logic [3:0] p, logic [7:0] ow,
                                bit chk, logic [2:0] st, logic [4:0] cnt);
        row_t w;
        w = '0;
        w.r = '{op, s, e, len, p, ow};
        w.chk = chk;
        w.x.st = st;
        w.x.cnt = cnt;
        return w;
    endfunction

    row_t dir_rows [$];

    function automatic void add_row(row_t w);
        dir_rows.insert(dir_rows.size(), w);
    endfunction

    initial
    begin
        add_row(mk(OP_LOCATE, 48'd5, 0, 0, 0, 0, 1, ST_NONE, 0));
        add_row(mk(OP_GAP, 0, AMAX, 49'h1_0000_0000_0000, 0, 0, 1, ST_NONE, 0));
        add_row(mk(OP_GAP, 0, AMAX, 0, 0, 0, 1, ST_INVALID, 0));
        add_row(mk(OP_APPEND, 48'd10, 48'd10, 0, 4'hF, 8'hFF, 1, ST_INVALID, 0));
        add_row(mk(OP_APPEND, 0, 48'h100, 0, 4'hF, 8'hFF, 1, ST_OK, 1));
        add_row(mk(OP_APPEND, 48'h80, 48'h200, 0, 4'h1, 8'h01, 1, ST_ORDER, 1));
        add_row(mk(OP_APPEND, 48'h200, 48'h300, 0, 4'h5, 8'hA5, 1, ST_OK, 2));
        add_row(mk(OP_APPEND, AMAX - 48'h10, AMAX, 0, 4'hA, 8'h5A, 1, ST_OK, 3));
        add_row(mk(OP_LOCATE, 48'h150, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_LOCATE, 48'h50, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_LOCATE, AMAX, 0, 0, 0, 0, 1, ST_NONE, 3));
        add_row(mk(OP_INTERSECT, 48'h100, 48'h200, 0, 0, 0, 1, ST_NONE, 3));
        add_row(mk(OP_INTERSECT, 48'h100, 48'h201, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_INTERSECT, 48'h5, 48'h5, 0, 0, 0, 1, ST_INVALID, 3));
        add_row(mk(OP_GAP, 0, AMAX, 49'h100, 0, 0, 0, 0, 0));
        add_row(mk(OP_GAP, 48'h10, 48'h5, 49'h1, 0, 0, 1, ST_INVALID, 3));
        add_row(mk(OP_PROTECT, 48'h80, 48'h280, 0, 4'h3, 0, 1, ST_NONE, 3));
        add_row(mk(OP_PROTECT, 48'h210, 48'h220, 0, 4'h3, 0, 0, 0, 0));
        add_row(mk(OP_PROTECT, 48'h9, 48'h9, 0, 4'h3, 0, 1, ST_INVALID, 5));
        add_row(mk(OP_UNMAP, 48'h40, 48'h60, 0, 0, 0, 0, 0, 0));
        add_row(mk(OP_UNMAP, 0, AMAX, 0, 0, 0, 1, ST_OK, 0));
        add_row(mk(OP_UNMAP, 48'h7, 48'h3, 0, 0, 0, 1, ST_INVALID, 0));
        add_row(mk(3'd7, AMAX, AMAX, 49'h1_FFFF_FFFF_FFFF, 4'hF, 8'hFF, 1,
                   ST_INVALID, 0));
        add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0, 1, ST_OK, 0));
    end

    rsp_t typed_rsp[$];
    bit   typed_chk[$];

    task automatic send(req_t r, bit chk, rsp_t x);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= r.op;
        addr_start <= r.s;
        addr_end <= r.e;
        gap_length <= r.len;
        new_permissions <= r.perm;
        owner_tag <= r.owner;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_rsp.insert(pending_rsp.size(), table_step(r));
        typed_rsp.insert(typed_rsp.size(), x);
        typed_chk.insert(typed_chk.size(), chk);
        op_hits[r.op]++;
        n_in++;
        @(negedge clk);
    endtask

    // random addresses: mostly a small window so operations interact
    function automatic logic [47:0] rnd_addr();
        case ($urandom_range(0, 9))
            0: return AMAX & 48'({$urandom(), $urandom()});
            1: return AMAX - 48'($urandom_range(0, 64));
            default: return 48'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic req_t rnd_req();
        req_t r;
        logic [47:0] t;
        r.perm = 4'($urandom());
        r.owner = 8'($urandom());
        r.s = rnd_addr();
        r.e = ($urandom_range(0, 4) == 0) ? rnd_addr() : r.s + 48'($urandom_range(1, 600));
        if ($urandom_range(0, 3) == 0 && r.e < r.s)
        begin
            t = r.s; r.s = r.e; r.e = t;
        end
        case ($urandom_range(0, 9))
            0: r.len = 49'({$urandom(), $urandom()});
            1: r.len = '0;
            default: r.len = 49'($urandom_range(1, 700));
        endcase
        case ($urandom_range(0, 99))
            0: r.op = OP_CLEAR;
            1: r.op = 3'd7;
            default: r.op = 3'($urandom_range(1, 6));
        endcase
        // appends mostly in order, past the current last end
        if (r.op == OP_APPEND && $urandom_range(0, 3) != 0)
        begin
            r.s = (tbl_n == 0) ? 48'($urandom_range(0, 200))
                               : tbl_e[tbl_n-1] + 48'($urandom_range(0, 64));
            r.e = r.s + 48'($urandom_range(1, 300));
        end
        // protect mostly inside one region so it is covered
        if (r.op == OP_PROTECT && tbl_n > 0 && $urandom_range(0, 2) != 0)
        begin
            t = tbl_s[$urandom_range(0, tbl_n - 1)];
            r.s = t + 48'($urandom_range(0, 3));
            r.e = r.s + 48'($urandom_range(1, 8));
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t exp_r;
        rsp_t tx;
        bit tc;
        if (out_valid && out_ready)
        begin
            got = '{status, contains, found, hit_start, hit_end, hit_permissions, hit_owner,
                    gap_address, region_count};
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                tx = typed_rsp.pop_front();
                tc = typed_chk.pop_front();
                if (tc && (tx.st != exp_r.st || tx.cnt != exp_r.cnt))
                begin
                    $display("%0t: row mismatch, expected st=%0d cnt=%0d actual st=%0d cnt=%0d",
                             $time, tx.st, tx.cnt, exp_r.st, exp_r.cnt);
                    errors++;
                end
                if (got !== exp_r)
                begin
                    $display("%0t: mismatch, expected %p actual %p", $time, exp_r, got);
                    errors++;
                end
                st_hits[got.st]++;
            end
            n_out++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t: watchdog timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int gap;
        int hold;
        @(negedge clk);
        while (1)
        begin
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                hold = 400;
                repeat (hold) @(negedge clk);
                hold_rx = 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        req_t r;
        row_t w;
        int drain;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            w = dir_rows[i];
            send(w.r, w.chk, w.x);
        end
        for (int i = 0; i < 1250; i++)
        begin
            if (i == 300)
                hold_rx = 1;
            if (i == 1100)
                quiet = 1;
            r = rnd_req();
            send(r, 0, '0);
        end
        in_valid <= 1'b0;
        drain = 0;
        while (pending_rsp.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (200) @(posedge clk);
        $display("Items %0d, results %0d; clr/app/loc/int/gap/prot/unmap/bad: %0d %0d %0d %0d",
                 n_in, n_out, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
        $display("  %0d %0d %0d %0d; ok/none/invalid/full/order: %0d %0d %0d %0d %0d",
                 op_hits[4], op_hits[5], op_hits[6], op_hits[7],
                 st_hits[0], st_hits[1], st_hits[2], st_hits[3], st_hits[4]);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
